FILE: src/bhpq_pkg.sv
// ---------------------------------------------------------------------------
// bhpq_pkg: shared types and constants for the binary heap priority queue
// Item layouts, command and status codes, sequencer states, key ordering.
// ---------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int KEY_W    = 64;
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 9;
  localparam int CAP_W    = 9;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INCREASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK     = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_SLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_LOWER = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [KEY_W-1:0]  key;
    logic [SLOT_W-1:0]        slot;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  result_key;
    logic [STATUS_W-1:0]      status;
    logic [FILL_W-1:0]        fill_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PEEK,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_FIN,
    S_INC_CHK,
    S_UP,
    S_UP_FIN,
    S_DONE
  } state_t;

  // True when a has strictly higher priority than b.
  function automatic logic beats(input logic signed [KEY_W-1:0] a,
                                 input logic signed [KEY_W-1:0] b,
                                 input logic                    min_mode);
    beats = min_mode ? (a < b) : (a > b);
  endfunction

endpackage

`default_nettype wire

FILE: src/bhpq_ram.sv
// ---------------------------------------------------------------------------
// bhpq_ram: heap entry store
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
  parameter int DEPTH = bhpq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic signed [bhpq_pkg::KEY_W-1:0] wr_data,
  input  wire logic [AW-1:0]                  rd_addr,
  output logic signed [bhpq_pkg::KEY_W-1:0]   rd_data
);
  import bhpq_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/binary_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// binary_heap_priority_queue: array-based binary heap of signed 64-bit keys
// One command per item: insert, pop, increase-key, peek; one result each.
// ---------------------------------------------------------------------------
// Sequencing: refused commands go from dispatch straight to the result; peek
//   reads the root; insert climbs one level per sift-up step; increase-key
//   first tests the old key in the slot, then climbs the same way; pop reads
//   the root and the last entry, then descends one level per left-child and
//   right-child step pair. A stalled output register adds its wait.
// Throughput: one item at a time; in_stall is high from accept until the
//   result is loaded into the output register, then the next item is taken.
// Reset: synchronous, active low; clears the entry count, order mode (max)
//   and capacity (256). The heap store is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue #(
  parameter int DEPTH = bhpq_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire bhpq_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output bhpq_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [bhpq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bhpq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);      // heap position
  localparam int PW = AW + 1;             // child position, may reach 2*DEPTH-1
  localparam int CW = $clog2(DEPTH + 1);  // entry count

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             order_r, order_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working payload
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;       // key being placed
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;       // hole position
  logic signed [KEY_W-1:0] bestk_r, bestk_nxt;   // best of hole key and left child
  logic                    lwin_r, lwin_nxt;     // left child beat the hole key
  logic signed [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // RAM port
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;
  logic [AW-1:0]           rd_addr;
  logic signed [KEY_W-1:0] rd_data;

  // Shared comparator
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_win;

  // Helpers
  logic [PW-1:0] left_pos, right_pos, best_pos, next_left;
  logic [PW-1:0] fill_ext;
  logic [AW-1:0] slot_a, up_pos, up_up_pos, ins_pos;
  logic          is_full, r_win;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    parent_of = (p - AW'(1)) >> 1;
  endfunction

  bhpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmp_win = beats(cmp_a, cmp_b, order_r);

  assign fill_ext  = PW'(count_r);
  assign left_pos  = {pos_r, 1'b1};
  assign right_pos = left_pos + PW'(1);
  assign slot_a    = AW'(slot_r);
  assign ins_pos   = AW'(count_r);
  assign up_pos    = parent_of(pos_r);
  assign up_up_pos = parent_of(up_pos);
  // Effective capacity saturates at the depth.
  assign is_full   = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= DEPTH);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    order_nxt     = order_r;
    cap_nxt       = cap_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    slot_nxt      = slot_r;
    pos_nxt       = pos_r;
    bestk_nxt     = bestk_r;
    lwin_nxt      = lwin_r;
    res_key_nxt   = res_key_r;
    status_nxt    = status_r;
    out_item_nxt  = out_item_r;
    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;
    rd_addr       = '0;
    cmp_a         = rd_data;
    cmp_b         = key_r;
    r_win         = 1'b0;
    best_pos      = left_pos;
    next_left     = {AW'(left_pos), 1'b1};

    // The user must issue configuration writes only while idle; not enforced here.
    if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER_MODE: order_nxt = cfg_data[0];
        CFG_CAPACITY:   cap_nxt   = CAP_W'(cfg_data);
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_item.command;
          key_nxt   = in_item.key;
          slot_nxt  = in_item.slot;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_key_nxt = '0;
        status_nxt  = STAT_OK;
        case (cmd_r)
          CMD_INSERT: begin
            if (is_full) begin
              status_nxt = STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = ins_pos;
              if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                state_nxt = S_DONE;
              end else begin
                rd_addr   = parent_of(ins_pos);
                state_nxt = S_UP;
              end
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_POP_ROOT;
            end
          end
          CMD_INCREASE: begin
            if (32'(slot_r) >= 32'(count_r)) begin
              status_nxt = STAT_SLOT;
              state_nxt  = S_DONE;
            end else begin
              rd_addr   = slot_a;
              state_nxt = S_INC_CHK;
            end
          end
          default: begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_PEEK;
            end
          end
        endcase
      end

      S_PEEK: begin
        res_key_nxt = rd_data;
        state_nxt   = S_DONE;
      end

      // Capture the root, shrink the heap and fetch the last entry.
      S_POP_ROOT: begin
        res_key_nxt = rd_data;
        count_nxt   = count_r - CW'(1);
        rd_addr     = AW'(count_r - CW'(1));
        state_nxt   = S_POP_LAST;
      end

      // The last entry becomes the hole key at the root.
      S_POP_LAST: begin
        key_nxt = rd_data;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else if (fill_ext > PW'(1)) begin
          rd_addr   = AW'(1);
          state_nxt = S_DN_L;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = rd_data;
          state_nxt = S_DONE;
        end
      end

      // Left child is in; test it against the hole key and fetch the right.
      S_DN_L: begin
        cmp_a     = rd_data;
        cmp_b     = key_r;
        lwin_nxt  = cmp_win;
        bestk_nxt = cmp_win ? rd_data : key_r;
        rd_addr   = AW'(right_pos);
        state_nxt = S_DN_R;
      end

      // Right child is in; it wins only if strictly better than the best so far.
      S_DN_R: begin
        cmp_a = rd_data;
        cmp_b = bestk_r;
        r_win = (right_pos < fill_ext) && cmp_win;
        if (!r_win && !lwin_r) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          best_pos  = r_win ? right_pos : left_pos;
          wr_en     = 1'b1;
          wr_data   = r_win ? rd_data : bestk_r;
          pos_nxt   = AW'(best_pos);
          next_left = {AW'(best_pos), 1'b1};
          if (next_left < fill_ext) begin
            rd_addr   = AW'(next_left);
            state_nxt = S_DN_L;
          end else begin
            state_nxt = S_DN_FIN;
          end
        end
      end

      S_DN_FIN: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end

      // Reject a key of lower priority, otherwise sift up from the slot.
      S_INC_CHK: begin
        cmp_a = rd_data;
        cmp_b = key_r;
        if (cmp_win) begin
          status_nxt = STAT_LOWER;
          state_nxt  = S_DONE;
        end else begin
          pos_nxt = slot_a;
          if (slot_a == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            state_nxt = S_DONE;
          end else begin
            rd_addr   = parent_of(slot_a);
            state_nxt = S_UP;
          end
        end
      end

      // Parent is in; move it down and fetch the next parent in the same cycle.
      S_UP: begin
        cmp_a = key_r;
        cmp_b = rd_data;
        wr_en = 1'b1;
        if (cmp_win) begin
          wr_data = rd_data;
          pos_nxt = up_pos;
          if (up_pos == '0) begin
            state_nxt = S_UP_FIN;
          end else begin
            rd_addr   = up_up_pos;
            state_nxt = S_UP;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_UP_FIN: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        state_nxt = S_DONE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.result_key = res_key_r;
          out_item_nxt.status     = status_r;
          out_item_nxt.fill_count = FILL_W'(count_r);
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      order_r     <= 1'b0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      order_r     <= order_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    pos_r      <= pos_nxt;
    bestk_r    <= bestk_nxt;
    lwin_r     <= lwin_nxt;
    res_key_r  <= res_key_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // An accepted item always starts in dispatch.
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISPATCH))
    else $error("accepted item did not reach dispatch");

  // The entry count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("entry count beyond depth");

  // Sift-up never runs with the hole at the root.
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (pos_r != '0))
    else $error("sift-up with hole at root");

  // A full answer leaves the entry count unchanged.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISPATCH && cmd_r == CMD_INSERT && is_full)
      |=> (count_r == $past(count_r)))
    else $error("rejected insert changed the count");

endmodule

`default_nettype wire
